### rtl/core/gbfp_pkg.sv
// package for the gnss binary frame parser
// holds the phase and status codes, the sync constants and the result type
// no dependencies
package gbfp_pkg;

	localparam logic [7:0] SYNC_FIRST  = 8'hB5;
	localparam logic [7:0] SYNC_SECOND = 8'h62;

	typedef enum logic [2:0] {
		PH_HUNT1   = 3'd0,
		PH_HUNT2   = 3'd1,
		PH_CLASS   = 3'd2,
		PH_ID      = 3'd3,
		PH_LEN_LO  = 3'd4,
		PH_LEN_HI  = 3'd5,
		PH_PAYLOAD = 3'd6,
		PH_CK_B    = 3'd7
	} phase_t;

	typedef enum logic [2:0] {
		ST_IGNORED = 3'd0,
		ST_HEADER  = 3'd1,
		ST_PAYLOAD = 3'd2,
		ST_CK_A_OK = 3'd3,
		ST_GOOD    = 3'd4,
		ST_FAIL    = 3'd5
	} status_t;

	typedef struct packed {
		status_t     status;
		logic [7:0]  payload_byte;
		logic [15:0] payload_index;
		logic        payload_kept;
		logic [7:0]  frame_class;
		logic [7:0]  frame_id;
		logic [15:0] frame_length;
	} result_t;

endpackage

### rtl/core/gbfp_if.sv
// channel interfaces for the gnss binary frame parser
// byte input, result output and max_payload write channel
// no dependencies
interface gbfp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface gbfp_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [7:0]  payload_byte;
	logic [15:0] payload_index;
	logic        payload_kept;
	logic [7:0]  frame_class;
	logic [7:0]  frame_id;
	logic [15:0] frame_length;

	modport source (
		output valid, output status, output payload_byte, output payload_index,
		output payload_kept, output frame_class, output frame_id, output frame_length,
		input ready
	);
	modport sink (
		input valid, input status, input payload_byte, input payload_index,
		input payload_kept, input frame_class, input frame_id, input frame_length,
		output ready
	);
endinterface

interface gbfp_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] max_payload;

	modport source (output valid, output max_payload, input ready);
	modport sink (input valid, input max_payload, output ready);
endinterface

### rtl/core/gnss_binary_frame_parser.sv
// top level of the gnss binary frame parser
// byte stream in, one result per byte out, max_payload write channel
// depends on gbfp_pkg, gbfp_if, gbfp_parser, gbfp_out_reg
//
// usage
//   rx: one received byte per request. the parser hunts for b5 62, captures
//     class, id and a little-endian 16-bit length, passes payload bytes with
//     index and kept flag, then checks the two fletcher checksum bytes.
//   res: one result per byte: status, payload fields, class, id, length.
//   cfg: writes max_payload, always ready; write only while the block idles.
//   timing: a result is registered and appears in the cycle after its byte is accepted.
//   throughput: one byte per cycle while res is not stalled; the parser state
//     updates in the cycle of acceptance and a single result register feeds the output.
//   stall: while res is stalled with a result held, rx.ready follows
//     res.ready, so a byte is taken in the same cycle the held result leaves.
//   reset: arst_n clears the phase to hunting, all sums and captured fields to
//     zero, max_payload to 65535 and empties the result register.
module gnss_binary_frame_parser (
	input  logic      clk,
	input  logic      arst_n,
	gbfp_in_if.sink   rx,
	gbfp_out_if.source res,
	gbfp_cfg_if.sink  cfg
);
	import gbfp_pkg::*;

	result_t res_d;
	result_t res_s1;
	logic    can_load;
	logic    valid_s1;
	logic    in_fire;

	assign rx.ready  = can_load;
	assign in_fire   = rx.valid && can_load;
	assign cfg.ready = 1'b1;

	gbfp_parser u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (in_fire),
		.rx_byte  (rx.rx_byte),
		.cfg_we   (cfg.valid),
		.cfg_data (cfg.max_payload),
		.res      (res_d)
	);

	gbfp_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (rx.valid),
		.res_d     (res_d),
		.out_ready (res.ready),
		.can_load  (can_load),
		.valid_s1  (valid_s1),
		.res_s1    (res_s1)
	);

	assign res.valid         = valid_s1;
	assign res.status        = res_s1.status;
	assign res.payload_byte  = res_s1.payload_byte;
	assign res.payload_index = res_s1.payload_index;
	assign res.payload_kept  = res_s1.payload_kept;
	assign res.frame_class   = res_s1.frame_class;
	assign res.frame_id      = res_s1.frame_id;
	assign res.frame_length  = res_s1.frame_length;

endmodule

### rtl/core/gbfp_parser.sv
// frame parser state: phase, fletcher sums, header capture, payload count
// computes one result per accepted byte and updates state on accept
// depends on gbfp_pkg
module gbfp_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_fire,
	input  logic [7:0]        rx_byte,
	input  logic              cfg_we,
	input  logic [15:0]       cfg_data,
	output gbfp_pkg::result_t res
);
	import gbfp_pkg::*;

	phase_t      phase_q, phase_d;
	logic [7:0]  sum_a_q, sum_a_d;
	logic [7:0]  sum_b_q, sum_b_d;
	logic [15:0] exp_len_q, exp_len_d;
	logic [15:0] byte_cnt_q, byte_cnt_d;
	logic [7:0]  class_q, class_d;
	logic [7:0]  id_q, id_d;
	logic [15:0] max_payload_q;
	logic [7:0]  base_a, base_b, add_a, add_b;

	// fletcher step, sums restart at the class byte
	always_comb begin
		base_a = (phase_q == PH_CLASS) ? 8'd0 : sum_a_q;
		base_b = (phase_q == PH_CLASS) ? 8'd0 : sum_b_q;
		add_a  = base_a + rx_byte;
		add_b  = base_b + add_a;
	end

	always_comb begin
		phase_d    = phase_q;
		sum_a_d    = sum_a_q;
		sum_b_d    = sum_b_q;
		exp_len_d  = exp_len_q;
		byte_cnt_d = byte_cnt_q;
		class_d    = class_q;
		id_d       = id_q;
		res        = '0;
		res.status = ST_IGNORED;
		unique case (phase_q)
			PH_HUNT1: begin
				if (rx_byte == SYNC_FIRST) begin
					phase_d    = PH_HUNT2;
					res.status = ST_HEADER;
				end
			end
			PH_HUNT2: begin
				if (rx_byte == SYNC_SECOND) begin
					phase_d    = PH_CLASS;
					res.status = ST_HEADER;
				end else begin
					phase_d = PH_HUNT1;
				end
			end
			PH_CLASS: begin
				class_d    = rx_byte;
				sum_a_d    = add_a;
				sum_b_d    = add_b;
				phase_d    = PH_ID;
				res.status = ST_HEADER;
			end
			PH_ID: begin
				id_d       = rx_byte;
				sum_a_d    = add_a;
				sum_b_d    = add_b;
				phase_d    = PH_LEN_LO;
				res.status = ST_HEADER;
			end
			PH_LEN_LO: begin
				exp_len_d  = {8'd0, rx_byte};
				sum_a_d    = add_a;
				sum_b_d    = add_b;
				phase_d    = PH_LEN_HI;
				res.status = ST_HEADER;
			end
			PH_LEN_HI: begin
				exp_len_d  = {rx_byte, exp_len_q[7:0]};
				byte_cnt_d = '0;
				sum_a_d    = add_a;
				sum_b_d    = add_b;
				phase_d    = PH_PAYLOAD;
				res.status = ST_HEADER;
			end
			PH_PAYLOAD: begin
				if (byte_cnt_q < exp_len_q) begin
					res.status        = ST_PAYLOAD;
					res.payload_byte  = rx_byte;
					res.payload_index = byte_cnt_q;
					res.payload_kept  = (byte_cnt_q < max_payload_q);
					sum_a_d           = add_a;
					sum_b_d           = add_b;
					byte_cnt_d        = byte_cnt_q + 16'd1;
				end else if (sum_a_q == rx_byte) begin
					phase_d    = PH_CK_B;
					res.status = ST_CK_A_OK;
				end else begin
					phase_d    = PH_HUNT1;
					res.status = ST_FAIL;
				end
			end
			PH_CK_B: begin
				if (sum_b_q == rx_byte) begin
					res.status       = ST_GOOD;
					res.frame_length = byte_cnt_q;
				end else begin
					res.status = ST_FAIL;
				end
				phase_d = PH_HUNT1;
			end
			default: begin
				phase_d = PH_HUNT1;
			end
		endcase
		res.frame_class = class_d;
		res.frame_id    = id_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HUNT1;
			sum_a_q    <= '0;
			sum_b_q    <= '0;
			exp_len_q  <= '0;
			byte_cnt_q <= '0;
			class_q    <= '0;
			id_q       <= '0;
		end else if (in_fire) begin
			phase_q    <= phase_d;
			sum_a_q    <= sum_a_d;
			sum_b_q    <= sum_b_d;
			exp_len_q  <= exp_len_d;
			byte_cnt_q <= byte_cnt_d;
			class_q    <= class_d;
			id_q       <= id_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q <= 16'hFFFF;
		end else if (cfg_we) begin
			max_payload_q <= cfg_data;
		end
	end

	a_payload_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAYLOAD |-> byte_cnt_q <= exp_len_q)
		else $error("payload count past announced length");

	a_ck_b_returns_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && phase_q == PH_CK_B |=> phase_q == PH_HUNT1)
		else $error("parser did not resume hunting after checksum b");

	a_good_reports_length: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && res.status == ST_GOOD |-> res.frame_length == exp_len_q)
		else $error("good frame length differs from announced length");

endmodule

### rtl/core/gbfp_out_reg.sv
// result register between the parser and the output channel
// holds one result, accepts a new one whenever it is empty or being drained
// depends on gbfp_pkg
module gbfp_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  gbfp_pkg::result_t res_d,
	input  logic              out_ready,
	output logic              can_load,
	output logic              valid_s1,
	output gbfp_pkg::result_t res_s1
);
	import gbfp_pkg::*;

	assign can_load = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (can_load) begin
			valid_s1 <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && can_load) begin
			res_s1 <= res_d;
		end
	end

	a_hold_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !out_ready |=> valid_s1 && $stable(res_s1))
		else $error("result changed while stalled");

	a_kept_only_payload: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && res_s1.status != ST_PAYLOAD |-> !res_s1.payload_kept)
		else $error("kept flag outside payload");

	a_length_only_good: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && res_s1.status != ST_GOOD |-> res_s1.frame_length == 16'd0)
		else $error("frame length outside good frame");

endmodule
